[src/fxd_pkg.sv]
package fxd_pkg;

  localparam int FRAME_MAX  = 4096;
  localparam int POS_W      = $clog2(FRAME_MAX);
  localparam int LEN_W      = 13;
  localparam int ADDR_W     = 3;
  localparam int MQ_DEPTH   = 4;
  localparam int MQ_PTR_W   = $clog2(MQ_DEPTH);
  localparam int MQ_CNT_W   = MQ_PTR_W + 1;
  localparam int OQ_DEPTH   = 8;
  localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W   = OQ_PTR_W + 1;
  localparam int RES_MAX    = 3;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(FRAME_MAX);

  // register index, taken from the word address of paddr
  localparam logic REG_FRAME_LENGTH = 1'b0;

  // item kinds as classified by the front end
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_ERR  = 2'd1;
  localparam logic [1:0] KIND_COMP = 2'd2;

  localparam logic WORD_PREFIX   = 1'b0;
  localparam logic WORD_RESIDUAL = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  count;
    logic [31:0] resid;
    logic        frame_done;
  } item_t;

  typedef struct packed {
    logic        word_kind;
    logic [31:0] packed_word;
    logic        status;
    logic        frame_end;
    logic        last;
  } res_t;

  function automatic logic [LEN_W-1:0] clamp_length(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (v > LEN_RESET) begin
      r = LEN_RESET;
    end
    return r;
  endfunction

endpackage

[src/fxd_front.sv]
module fxd_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic                         in_op,
  input  logic [31:0]                  in_value,
  output logic                         full,
  input  logic                         cfg_clear,
  input  logic [fxd_pkg::LEN_W-1:0]    frame_len,
  input  logic [fxd_pkg::MQ_CNT_W-1:0] q_count,
  output logic                         q_push,
  output fxd_pkg::item_t               q_item
);
  import fxd_pkg::*;

  logic [31:0]       ref_mem [FRAME_MAX];
  logic [31:0]       rdata_r;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              loaded_r, loaded_nxt;
  logic              s1_valid_r;
  logic [1:0]        s1_kind_r;
  logic [31:0]       s1_value_r;
  logic              s1_done_r;
  logic              accept;
  logic              mem_we;
  logic              frame_done;
  logic [1:0]        kind;
  logic [31:0]       diff;
  logic [1:0]        count;
  logic [31:0]       resid;

  // Room is reserved for the item already in the read stage, so that stage never stalls.
  assign full   = ({1'b0, q_count} + {{MQ_CNT_W{1'b0}}, s1_valid_r}) >= (MQ_CNT_W+1)'(MQ_DEPTH);
  assign accept = push && !full;

  always_comb begin
    if (!in_op) begin
      kind = KIND_LOAD;
    end else if (!loaded_r) begin
      kind = KIND_ERR;
    end else begin
      kind = KIND_COMP;
    end
  end

  assign mem_we     = accept && (kind != KIND_ERR);
  assign frame_done = ({1'b0, pos_r} + LEN_W'(1)) >= frame_len;

  always_comb begin
    pos_nxt    = pos_r;
    loaded_nxt = loaded_r;
    if (cfg_clear) begin
      pos_nxt    = '0;
      loaded_nxt = 1'b0;
    end else if (mem_we) begin
      if (frame_done) begin
        pos_nxt = '0;
        if (kind == KIND_LOAD) begin
          loaded_nxt = 1'b1;
        end
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  // Read-first port: the read returns the old entry while the new word is written.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ref_mem[pos_r] <= in_value;
    end
    rdata_r <= ref_mem[pos_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      loaded_r   <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      loaded_r   <= loaded_nxt;
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r  <= kind;
      s1_value_r <= in_value;
      s1_done_r  <= frame_done;
    end
  end

  assign diff = s1_value_r ^ rdata_r;

  always_comb begin
    if (diff[31:24] != '0) begin
      count = 2'd0;
      resid = diff;
    end else if (diff[23:16] != '0) begin
      count = 2'd1;
      resid = {8'b0, diff[23:0]};
    end else if (diff[15:8] != '0) begin
      count = 2'd2;
      resid = {16'b0, diff[15:0]};
    end else begin
      count = 2'd3;
      resid = {24'b0, diff[7:0]};
    end
  end

  assign q_push            = s1_valid_r;
  assign q_item.kind       = s1_kind_r;
  assign q_item.count      = count;
  assign q_item.resid      = resid;
  assign q_item.frame_done = s1_done_r;

endmodule

[src/fxd_queue.sv]
module fxd_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  fxd_pkg::item_t               item_in,
  input  logic                         pop,
  output fxd_pkg::item_t               item_out,
  output logic                         empty,
  output logic [fxd_pkg::MQ_CNT_W-1:0] count
);
  import fxd_pkg::*;

  item_t               slot_r [MQ_DEPTH];
  logic [MQ_PTR_W-1:0] wptr_r, rptr_r;
  logic [MQ_CNT_W-1:0] count_r;
  logic                do_pop;

  assign empty    = (count_r == '0);
  assign count    = count_r;
  assign item_out = slot_r[rptr_r];
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + MQ_PTR_W'(1);
      end
      if (do_pop) begin
        rptr_r <= rptr_r + MQ_PTR_W'(1);
      end
      count_r <= count_r + {{(MQ_CNT_W-1){1'b0}}, push} - {{(MQ_CNT_W-1){1'b0}}, do_pop};
    end
  end

endmodule

[src/fxd_packer.sv]
module fxd_packer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_clear,
  input  fxd_pkg::item_t               item,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  logic [fxd_pkg::OQ_CNT_W-1:0] oq_count,
  output logic [1:0]                   res_n,
  output fxd_pkg::res_t                res [fxd_pkg::RES_MAX]
);
  import fxd_pkg::*;

  logic [31:0] pacc_r, pacc_nxt;
  logic [3:0]  pfill_r, pfill_nxt;
  logic [31:0] racc_r, racc_nxt;
  logic [4:0]  rfill_r, rfill_nxt;
  logic [5:0]  bits;
  logic [6:0]  sum;
  logic [6:0]  sh;
  logic [63:0] tmp;
  logic        rcomplete;
  logic [31:0] racc_a;
  logic [4:0]  rfill_a;
  logic [31:0] pacc_or;
  logic [3:0]  pfill_a;
  logic        pcomplete;
  logic        cand_v [4];
  res_t        cand   [4];
  logic [1:0]  n;
  res_t        res_c  [RES_MAX];

  assign q_pop = !q_empty && (oq_count <= OQ_CNT_W'(OQ_DEPTH - RES_MAX));

  assign bits = {(3'd4 - {1'b0, item.count}), 3'b000};
  assign sum  = {2'b00, rfill_r} + {1'b0, bits};
  assign sh   = 7'd64 - sum;
  assign tmp  = {racc_r, 32'b0} | ({32'b0, item.resid} << sh);
  assign rcomplete = (sum[6:5] != 2'b00);
  assign racc_a    = rcomplete ? tmp[31:0] : tmp[63:32];
  // With at most 63 bits in hand, the fill after a completed word is the low five bits.
  assign rfill_a   = sum[4:0];

  assign pacc_or   = pacc_r | ({item.count, 30'b0} >> {pfill_r, 1'b0});
  assign pfill_a   = pfill_r + 4'd1;
  assign pcomplete = (pfill_a == 4'd0);

  always_comb begin
    cand_v[0] = pcomplete;
    cand[0]   = '{word_kind: WORD_PREFIX, packed_word: pacc_or, status: 1'b0,
                  frame_end: item.frame_done, last: 1'b0};
    cand_v[1] = rcomplete;
    cand[1]   = '{word_kind: WORD_RESIDUAL, packed_word: tmp[63:32], status: 1'b0,
                  frame_end: item.frame_done, last: 1'b0};
    cand_v[2] = item.frame_done && !pcomplete;
    cand[2]   = '{word_kind: WORD_PREFIX, packed_word: pacc_or, status: 1'b0,
                  frame_end: 1'b1, last: 1'b0};
    cand_v[3] = item.frame_done && (rfill_a != 5'd0);
    cand[3]   = '{word_kind: WORD_RESIDUAL, packed_word: racc_a, status: 1'b0,
                  frame_end: 1'b1, last: 1'b0};
  end

  always_comb begin
    n = 2'd0;
    for (int i = 0; i < RES_MAX; i++) begin
      res_c[i] = '0;
    end
    if (item.kind == KIND_ERR) begin
      res_c[0] = '{word_kind: WORD_PREFIX, packed_word: 32'b0, status: 1'b1,
                   frame_end: 1'b0, last: 1'b0};
      n = 2'd1;
    end else if (item.kind == KIND_COMP) begin
      for (int k = 0; k < 4; k++) begin
        if (cand_v[k] && (n != 2'd3)) begin
          res_c[n] = cand[k];
          n = n + 2'd1;
        end
      end
    end
    for (int i = 0; i < RES_MAX; i++) begin
      res[i] = res_c[i];
      if ((n != 2'd0) && (2'(i) == n - 2'd1)) begin
        res[i].last = 1'b1;
      end
    end
    res_n = q_pop ? n : 2'd0;
  end

  always_comb begin
    pacc_nxt  = pacc_r;
    pfill_nxt = pfill_r;
    racc_nxt  = racc_r;
    rfill_nxt = rfill_r;
    if (cfg_clear || (q_pop && (item.kind == KIND_LOAD)) ||
        (q_pop && (item.kind == KIND_COMP) && item.frame_done)) begin
      pacc_nxt  = '0;
      pfill_nxt = '0;
      racc_nxt  = '0;
      rfill_nxt = '0;
    end else if (q_pop && (item.kind == KIND_COMP)) begin
      pacc_nxt  = pcomplete ? 32'b0 : pacc_or;
      pfill_nxt = pfill_a;
      racc_nxt  = racc_a;
      rfill_nxt = rfill_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pacc_r  <= '0;
      pfill_r <= '0;
      racc_r  <= '0;
      rfill_r <= '0;
    end else begin
      pacc_r  <= pacc_nxt;
      pfill_r <= pfill_nxt;
      racc_r  <= racc_nxt;
      rfill_r <= rfill_nxt;
    end
  end

endmodule

[src/fxd_out_queue.sv]
module fxd_out_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [1:0]                   push_n,
  input  fxd_pkg::res_t                res [fxd_pkg::RES_MAX],
  input  logic                         pop,
  output fxd_pkg::res_t                head,
  output logic                         empty,
  output logic [fxd_pkg::OQ_CNT_W-1:0] count
);
  import fxd_pkg::*;

  res_t                slot_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wptr_r, rptr_r;
  logic [OQ_CNT_W-1:0] count_r;
  logic                do_pop;

  assign empty  = (count_r == '0);
  assign count  = count_r;
  assign head   = slot_r[rptr_r];
  assign do_pop = pop && !empty;

  // Up to three beats land in consecutive slots in one cycle.
  always_ff @(posedge clk) begin
    for (int k = 0; k < RES_MAX; k++) begin
      if (2'(k) < push_n) begin
        slot_r[wptr_r + OQ_PTR_W'(k)] <= res[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r <= wptr_r + OQ_PTR_W'(push_n);
      if (do_pop) begin
        rptr_r <= rptr_r + OQ_PTR_W'(1);
      end
      count_r <= count_r + OQ_CNT_W'(push_n) - {{(OQ_CNT_W-1){1'b0}}, do_pop};
    end
  end

endmodule

[src/frame_xor_delta_compressor.sv]
// Channel   Handshake                Payload
// input     push / full              in_op, in_value
// result    empty / pop              out_word_kind, out_packed_word, out_status,
//                                    out_frame_end, out_last
// config    psel penable pwrite      paddr, pwdata, prdata (frame_length at 0x0)
//
// One item is taken every cycle while full is low; its first beat reaches the result ports
// through the registered read of the reference memory, the item queue and the result queue.
// Further beats of the same item follow at one a cycle while pop is held.
// An item yields up to three beats, so the result port, at one beat a cycle, bounds the rate.
// full rises when the four-entry queue between front and packer cannot take more;
// the packer waits while the eight-entry result queue has fewer than three free slots.
// Reset is synchronous; the reference memory is not cleared and holds no valid bits.
module frame_xor_delta_compressor (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic                       in_op,
  input  logic [31:0]                in_value,
  output logic                       empty,
  input  logic                       pop,
  output logic                       out_word_kind,
  output logic [31:0]                out_packed_word,
  output logic                       out_status,
  output logic                       out_frame_end,
  output logic                       out_last,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fxd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import fxd_pkg::*;

  logic [LEN_W-1:0]    frame_len_r;
  logic                cfg_clear;
  logic [MQ_CNT_W-1:0] mq_count;
  logic                mq_push;
  item_t               mq_in;
  item_t               mq_out;
  logic                mq_empty;
  logic                mq_pop;
  logic [OQ_CNT_W-1:0] oq_count;
  logic [1:0]          res_n;
  res_t                res [RES_MAX];
  res_t                head;

  assign pready    = 1'b1;
  assign cfg_clear = psel && penable && pwrite && (paddr[2] == REG_FRAME_LENGTH);
  assign prdata    = (paddr[2] == REG_FRAME_LENGTH) ? {{(32-LEN_W){1'b0}}, frame_len_r}
                                                     : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r <= LEN_RESET;
    end else if (cfg_clear) begin
      frame_len_r <= clamp_length(pwdata[LEN_W-1:0]);
    end
  end

  fxd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_op     (in_op),
    .in_value  (in_value),
    .full      (full),
    .cfg_clear (cfg_clear),
    .frame_len (frame_len_r),
    .q_count   (mq_count),
    .q_push    (mq_push),
    .q_item    (mq_in)
  );

  fxd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (mq_push),
    .item_in  (mq_in),
    .pop      (mq_pop),
    .item_out (mq_out),
    .empty    (mq_empty),
    .count    (mq_count)
  );

  fxd_packer u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_clear (cfg_clear),
    .item      (mq_out),
    .q_empty   (mq_empty),
    .q_pop     (mq_pop),
    .oq_count  (oq_count),
    .res_n     (res_n),
    .res       (res)
  );

  fxd_out_queue u_out_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_n (res_n),
    .res    (res),
    .pop    (pop),
    .head   (head),
    .empty  (empty),
    .count  (oq_count)
  );

  assign out_word_kind   = head.word_kind;
  assign out_packed_word = head.packed_word;
  assign out_status      = head.status;
  assign out_frame_end   = head.frame_end;
  assign out_last        = head.last;

endmodule

[src/fxd_checker.sv]
module fxd_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       full,
  input  logic                       empty,
  input  logic                       pop,
  input  logic                       out_word_kind,
  input  logic [31:0]                out_packed_word,
  input  logic                       out_status,
  input  logic                       out_frame_end,
  input  logic                       out_last,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fxd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic [31:0]                prdata
);
  import fxd_pkg::*;

  // A waiting beat must not change until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> ($stable(out_packed_word) && $stable(out_word_kind) &&
                          $stable(out_last) && $stable(out_frame_end)))
    else $error("result beat changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

  // An early compress yields a single bare error beat.
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status) |-> (out_last && !out_frame_end &&
                                (out_packed_word == 32'b0) && (out_word_kind == WORD_PREFIX)))
    else $error("malformed error beat");

  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(psel && penable && pwrite && (paddr[2] == REG_FRAME_LENGTH) &&
                          (pwdata[LEN_W-1:0] != '0) && (pwdata[LEN_W-1:0] <= LEN_RESET)) &&
     (paddr[2] == REG_FRAME_LENGTH))
    |-> (prdata[LEN_W-1:0] == $past(pwdata[LEN_W-1:0])))
    else $error("frame length read back wrong");

endmodule

bind frame_xor_delta_compressor fxd_checker u_fxd_checker (.*);
